FILE: rtl/core/prts_pkg.sv
// ----------------------------------------------------------------------------
// prts_pkg
// Shared types and constants of the priority ready-table scheduler.
// ----------------------------------------------------------------------------
package prts_pkg;

    localparam int PRIO_W   = 5;
    localparam int ID_W     = 4;
    localparam int IDX_W    = 6;
    localparam int NEST_W   = 8;
    localparam int STAMP_W  = 8;
    localparam int DISP_W   = 32;
    localparam int LOCK_W   = 8;

    localparam logic [NEST_W-1:0]  NEST_MAX  = 8'd255;
    localparam logic [STAMP_W-1:0] STAMP_MAX = 8'd255;
    localparam logic [LOCK_W-1:0]  LOCK_MAX  = 8'd255;

    // operation codes on the request channel
    typedef enum logic [2:0] {
        MODE_CREATE  = 3'd0,
        MODE_SUSPEND = 3'd1,
        MODE_WAKEUP  = 3'd2,
        MODE_DELETE  = 3'd3,
        MODE_LOCK    = 3'd4,
        MODE_UNLOCK  = 3'd5,
        MODE_REQDEL  = 3'd6
    } mode_e;

    // per-cell command codes
    typedef enum logic [2:0] {
        CMD_NOP,
        CMD_CREATE,
        CMD_SUSPEND,
        CMD_WAKEUP,
        CMD_DELETE,
        CMD_REQDEL,
        CMD_DISPATCH
    } cmd_kind_e;

    // command broadcast to every cell
    typedef struct packed {
        cmd_kind_e         kind;
        logic [IDX_W-1:0]  id;
        logic [PRIO_W-1:0] prio;
        logic              bump;
    } cmd_t;

    // candidate passed along the cell chain
    typedef struct packed {
        logic               valid;
        logic [PRIO_W-1:0]  prio;
        logic [STAMP_W-1:0] stamp;
        logic [IDX_W-1:0]   idx;
    } cand_t;

    // record of one task as seen by the control
    typedef struct packed {
        logic [PRIO_W-1:0] prio;
        logic              ready;
        logic              susp;
        logic [NEST_W-1:0] nest;
        logic              dreq;
        logic [DISP_W-1:0] disp;
    } view_t;

endpackage

FILE: rtl/core/prts_if.sv
// ----------------------------------------------------------------------------
// prts_in_if / prts_out_if
// Valid/ready channels for scheduler requests and results.
// ----------------------------------------------------------------------------
interface prts_in_if;
    logic                          valid;
    logic                          ready;
    logic [2:0]                    mode;
    logic [prts_pkg::ID_W-1:0]     task_id;
    logic [prts_pkg::PRIO_W-1:0]   prio;

    modport source (output valid, mode, task_id, prio, input ready);
    modport sink (input valid, mode, task_id, prio, output ready);
endinterface

interface prts_out_if;
    logic                          valid;
    logic                          ready;
    logic [prts_pkg::ID_W-1:0]     current_task;
    logic                          switched;
    logic                          none_ready;
    logic                          current_delete_requested;
    logic [prts_pkg::DISP_W-1:0]   addressed_dispatches;
    logic [prts_pkg::NEST_W-1:0]   addressed_suspend_count;
    logic [prts_pkg::LOCK_W-1:0]   lock_depth;

    modport source (output valid, current_task, switched, none_ready,
                    current_delete_requested, addressed_dispatches,
                    addressed_suspend_count, lock_depth, input ready);
    modport sink (input valid, current_task, switched, none_ready,
                  current_delete_requested, addressed_dispatches,
                  addressed_suspend_count, lock_depth, output ready);
endinterface

FILE: rtl/core/prts_cell.sv
// ----------------------------------------------------------------------------
// prts_cell
// One task record plus one stage of the best-candidate chain.
// ----------------------------------------------------------------------------
module prts_cell #(
    parameter int IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  prts_pkg::cmd_t  cmd,
    input  prts_pkg::cand_t cand_in,
    output prts_pkg::cand_t cand_out,
    output prts_pkg::view_t view
);

    localparam logic [prts_pkg::IDX_W-1:0] MY_IDX = prts_pkg::IDX_W'(IDX);

    logic [prts_pkg::PRIO_W-1:0]  prio_reg, prio_next;
    logic                         ready_reg, ready_next;
    logic                         susp_reg, susp_next;
    logic [prts_pkg::NEST_W-1:0]  nest_reg, nest_next;
    logic                         dreq_reg, dreq_next;
    logic [prts_pkg::DISP_W-1:0]  disp_reg, disp_next;
    logic [prts_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    prts_pkg::cand_t              cand_reg, cand_next;
    prts_pkg::cand_t              mine;
    logic                         me;
    logic                         better;

    assign me = (cmd.id == MY_IDX);

    // record update
    always_comb
    begin
        prio_next  = prio_reg;
        ready_next = ready_reg;
        susp_next  = susp_reg;
        nest_next  = nest_reg;
        dreq_next  = dreq_reg;
        disp_next  = disp_reg;
        stamp_next = stamp_reg;
        case (cmd.kind)
            prts_pkg::CMD_CREATE:
                if (me)
                begin
                    prio_next  = cmd.prio;
                    susp_next  = 1'b0;
                    nest_next  = '0;
                    dreq_next  = 1'b0;
                    disp_next  = '0;
                    ready_next = 1'b1;
                    stamp_next = '0;
                end
            prts_pkg::CMD_SUSPEND:
                if (me)
                begin
                    if (nest_reg != prts_pkg::NEST_MAX)
                        nest_next = nest_reg + 1'b1;
                    if (nest_reg == '0)
                    begin
                        susp_next  = 1'b1;
                        ready_next = 1'b0;
                    end
                end
            prts_pkg::CMD_WAKEUP:
                if (me && susp_reg)
                begin
                    nest_next = nest_reg - 1'b1;
                    if (nest_reg == prts_pkg::NEST_W'(1))
                    begin
                        susp_next  = 1'b0;
                        ready_next = 1'b1;
                        stamp_next = '0;
                    end
                end
            prts_pkg::CMD_DELETE:
                if (me && !susp_reg)
                    ready_next = 1'b0;
            prts_pkg::CMD_REQDEL:
                if (me)
                    dreq_next = 1'b1;
            prts_pkg::CMD_DISPATCH:
                if (me)
                    disp_next = disp_reg + 1'b1;
            default:
                ;
        endcase
        // age peers of the same priority when another task turns ready
        if (cmd.bump && !me && ready_reg && prio_reg == cmd.prio
            && stamp_reg != prts_pkg::STAMP_MAX)
            stamp_next = stamp_reg + 1'b1;
    end

    // candidate chain stage: earlier cell wins ties
    always_comb
    begin
        mine.valid = ready_reg;
        mine.prio  = prio_reg;
        mine.stamp = stamp_reg;
        mine.idx   = MY_IDX;
        better = ready_reg && (!cand_in.valid || prio_reg < cand_in.prio
                 || (prio_reg == cand_in.prio && stamp_reg < cand_in.stamp));
        cand_next = better ? mine : cand_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prio_reg  <= '0;
            ready_reg <= 1'b0;
            susp_reg  <= 1'b0;
            nest_reg  <= '0;
            dreq_reg  <= 1'b0;
            disp_reg  <= '0;
            stamp_reg <= '0;
            cand_reg  <= '0;
        end
        else
        begin
            prio_reg  <= prio_next;
            ready_reg <= ready_next;
            susp_reg  <= susp_next;
            nest_reg  <= nest_next;
            dreq_reg  <= dreq_next;
            disp_reg  <= disp_next;
            stamp_reg <= stamp_next;
            cand_reg  <= cand_next;
        end
    end

    assign cand_out   = cand_reg;
    assign view.prio  = prio_reg;
    assign view.ready = ready_reg;
    assign view.susp  = susp_reg;
    assign view.nest  = nest_reg;
    assign view.dreq  = dreq_reg;
    assign view.disp  = disp_reg;

    // a suspended task is never in the ready table
    assert property (@(posedge clk) disable iff (!rst_n) susp_reg |-> !ready_reg)
        else $error("suspended task marked ready");
    // a suspended task always has a nonzero nesting count
    assert property (@(posedge clk) disable iff (!rst_n) susp_reg |-> nest_reg != '0)
        else $error("suspended task with zero nesting");

endmodule

FILE: rtl/core/priority_ready_table_scheduler.sv
// ----------------------------------------------------------------------------
// priority_ready_table_scheduler
// Ready-table task scheduler built from a chain of per-task cells.
// ----------------------------------------------------------------------------
// usage
//   request: valid/ready channel carrying mode, task_id and prio; one
//   transaction is one scheduler operation.
//   result: valid/ready channel, exactly one transaction per request, in
//   order, giving the running task, switch flag, ready/lock status and the
//   addressed task's dispatch and suspend counts.
// timing
//   an operation without a reschedule goes through ST_APPLY and ST_RESULT to
//   the result register; a reschedule adds ST_SWEEP and ST_DECIDE, since the
//   best candidate ripples through the cell chain one cell per cycle.
//   one operation is in flight at a time; a new request is taken as soon as
//   the control is idle, even while the previous result waits.
// reset
//   rst_n clears every task record, the lock depth and the running task
//   (task 0); no result is pending after reset.
// stall
//   a result held by the receiver keeps the next operation waiting in its
//   final step until the result register frees up.
// ----------------------------------------------------------------------------
module priority_ready_table_scheduler #(
    parameter int NUM_TASKS      = 16,
    parameter int NUM_PRIORITIES = 32
) (
    input  logic       clk,
    input  logic       rst_n,
    prts_in_if.sink    request,
    prts_out_if.source result
);

    localparam int CNT_W = $clog2(NUM_TASKS + 1);
    localparam logic [6:0] PRIO_MAX = 7'(NUM_PRIORITIES - 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_SWEEP,
        ST_DECIDE,
        ST_RESULT
    } state_t;

    state_t                        state_reg;
    logic [2:0]                    mode_reg;
    logic [prts_pkg::ID_W-1:0]     id_reg;
    logic [prts_pkg::PRIO_W-1:0]   prio_reg;
    logic [prts_pkg::ID_W-1:0]     running_reg;
    logic [prts_pkg::LOCK_W-1:0]   lock_reg, lock_next;
    logic                          switched_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic                          out_valid_reg;
    logic [prts_pkg::ID_W-1:0]     out_task_reg;
    logic                          out_sw_reg;
    logic                          out_none_reg;
    logic                          out_dreq_reg;
    logic [prts_pkg::DISP_W-1:0]   out_disp_reg;
    logic [prts_pkg::NEST_W-1:0]   out_nest_reg;
    logic [prts_pkg::LOCK_W-1:0]   out_lock_reg;

    prts_pkg::cmd_t                cmd;
    prts_pkg::cand_t               chain [NUM_TASKS+1];
    prts_pkg::view_t               views [NUM_TASKS];
    prts_pkg::view_t               addr_view;
    prts_pkg::view_t               run_view;
    logic [NUM_TASKS-1:0]          match;
    logic                          hit;
    logic                          any_ready;
    logic                          resched;
    logic                          addressed;
    logic                          accept;
    logic                          load_out;
    logic [prts_pkg::PRIO_W-1:0]   prio_sat;
    prts_pkg::cand_t               best;

    assign accept = request.valid && request.ready;
    assign request.ready = (state_reg == ST_IDLE);
    assign prio_sat = ({2'b00, request.prio} > PRIO_MAX) ? PRIO_MAX[prts_pkg::PRIO_W-1:0]
                                                         : request.prio;

    // task cells
    assign chain[0] = '0;
    for (genvar i = 0; i < NUM_TASKS; i++)
    begin : g_cell
        prts_cell #(.IDX(i)) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cmd      (cmd),
            .cand_in  (chain[i]),
            .cand_out (chain[i+1]),
            .view     (views[i])
        );
    end
    assign best = chain[NUM_TASKS];

    // addressed and running task records
    always_comb
    begin
        addr_view = '0;
        run_view  = '0;
        any_ready = 1'b0;
        for (int i = 0; i < NUM_TASKS; i++)
        begin
            match[i] = ({2'b00, id_reg} == prts_pkg::IDX_W'(i));
            if (match[i])
                addr_view = views[i];
            if ({2'b00, running_reg} == prts_pkg::IDX_W'(i))
                run_view = views[i];
            any_ready = any_ready | views[i].ready;
        end
    end
    assign hit = |match;

    // command to the cells, lock update and reschedule request
    always_comb
    begin
        cmd.kind = prts_pkg::CMD_NOP;
        cmd.id   = {2'b00, id_reg};
        cmd.prio = prio_reg;
        cmd.bump = 1'b0;
        lock_next = lock_reg;
        resched   = 1'b0;
        if (state_reg == ST_APPLY)
        begin
            unique case (mode_reg)
                prts_pkg::MODE_CREATE:
                begin
                    cmd.kind = prts_pkg::CMD_CREATE;
                    cmd.bump = hit;
                end
                prts_pkg::MODE_SUSPEND:
                begin
                    cmd.kind = prts_pkg::CMD_SUSPEND;
                    resched  = hit && addr_view.nest == '0 && id_reg == running_reg;
                end
                prts_pkg::MODE_WAKEUP:
                begin
                    cmd.kind = prts_pkg::CMD_WAKEUP;
                    cmd.prio = addr_view.prio;
                    resched  = hit && addr_view.susp
                               && addr_view.nest == prts_pkg::NEST_W'(1);
                    cmd.bump = resched;
                end
                prts_pkg::MODE_DELETE:
                begin
                    cmd.kind = prts_pkg::CMD_DELETE;
                    resched  = hit && id_reg == running_reg;
                end
                prts_pkg::MODE_LOCK:
                    if (lock_reg != prts_pkg::LOCK_MAX)
                        lock_next = lock_reg + 1'b1;
                prts_pkg::MODE_UNLOCK:
                    if (lock_reg != '0)
                    begin
                        lock_next = lock_reg - 1'b1;
                        resched   = (lock_reg == prts_pkg::LOCK_W'(1));
                    end
                prts_pkg::MODE_REQDEL:
                    cmd.kind = prts_pkg::CMD_REQDEL;
                default:
                    ;
            endcase
        end
        else if (state_reg == ST_DECIDE && best.valid
                 && best.idx != {2'b00, running_reg})
        begin
            cmd.kind = prts_pkg::CMD_DISPATCH;
            cmd.id   = best.idx;
        end
    end

    assign addressed = hit && mode_reg != prts_pkg::MODE_LOCK
                       && mode_reg != prts_pkg::MODE_UNLOCK && mode_reg != 3'd7;
    assign load_out  = (state_reg == ST_RESULT) && (!out_valid_reg || result.ready);

    // control sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= '0;
            id_reg        <= '0;
            prio_reg      <= '0;
            running_reg   <= '0;
            lock_reg      <= '0;
            switched_reg  <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_task_reg  <= '0;
            out_sw_reg    <= 1'b0;
            out_none_reg  <= 1'b0;
            out_dreq_reg  <= 1'b0;
            out_disp_reg  <= '0;
            out_nest_reg  <= '0;
            out_lock_reg  <= '0;
        end
        else
        begin
            if (result.ready && out_valid_reg && !load_out)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        mode_reg     <= request.mode;
                        id_reg       <= request.task_id;
                        prio_reg     <= prio_sat;
                        switched_reg <= 1'b0;
                        state_reg    <= ST_APPLY;
                    end
                ST_APPLY:
                begin
                    lock_reg <= lock_next;
                    cnt_reg  <= CNT_W'(NUM_TASKS - 1);
                    if (resched && lock_next == '0)
                        state_reg <= ST_SWEEP;
                    else
                        state_reg <= ST_RESULT;
                end
                ST_SWEEP:
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                    if (cnt_reg == '0)
                        state_reg <= ST_DECIDE;
                end
                ST_DECIDE:
                begin
                    if (cmd.kind == prts_pkg::CMD_DISPATCH)
                    begin
                        running_reg  <= best.idx[prts_pkg::ID_W-1:0];
                        switched_reg <= 1'b1;
                    end
                    state_reg <= ST_RESULT;
                end
                ST_RESULT:
                    if (load_out)
                    begin
                        out_valid_reg <= 1'b1;
                        out_task_reg  <= running_reg;
                        out_sw_reg    <= switched_reg;
                        out_none_reg  <= !any_ready;
                        out_dreq_reg  <= run_view.dreq;
                        out_disp_reg  <= addressed ? addr_view.disp : '0;
                        out_nest_reg  <= addressed ? addr_view.nest : '0;
                        out_lock_reg  <= lock_reg;
                        state_reg     <= ST_IDLE;
                    end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    assign result.valid                    = out_valid_reg;
    assign result.current_task             = out_task_reg;
    assign result.switched                 = out_sw_reg;
    assign result.none_ready               = out_none_reg;
    assign result.current_delete_requested = out_dreq_reg;
    assign result.addressed_dispatches     = out_disp_reg;
    assign result.addressed_suspend_count  = out_nest_reg;
    assign result.lock_depth               = out_lock_reg;

    // a reschedule sweep only runs with the scheduler unlocked
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_SWEEP |-> lock_reg == '0)
        else $error("sweep while locked");
    // at most one cell answers to a task id
    assert property (@(posedge clk) disable iff (!rst_n) $onehot0(match))
        else $error("several cells match one id");
    // a switch always lands on a ready task
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.switched |-> !result.none_ready)
        else $error("switch reported with no ready task");

endmodule

FILE: tb/sv/priority_ready_table_scheduler_tb.sv
// ----------------------------------------------------------------------------
// priority_ready_table_scheduler_tb
// Drives scheduler operations with random gaps and receiver stalls, predicts
// every result with a behavioral task table and compares each field in order.
// ----------------------------------------------------------------------------
module priority_ready_table_scheduler_tb;

    localparam int NTASK    = 16;
    localparam int NPRIO    = 32;
    localparam int WD_LIMIT = 20000;

    typedef struct packed {
        logic [2:0]                  mode;
        logic [prts_pkg::ID_W-1:0]   task_id;
        logic [prts_pkg::PRIO_W-1:0] prio;
    } op_t;

    typedef struct packed {
        logic [prts_pkg::ID_W-1:0]   current_task;
        logic                        switched;
        logic                        none_ready;
        logic                        current_delete_requested;
        logic [prts_pkg::DISP_W-1:0] addressed_dispatches;
        logic [prts_pkg::NEST_W-1:0] addressed_suspend_count;
        logic [prts_pkg::LOCK_W-1:0] lock_depth;
    } res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    prts_in_if  req_ch ();
    prts_out_if res_ch ();

    priority_ready_table_scheduler dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch.sink),
        .result  (res_ch.source)
    );

    always #2 clk = ~clk;

    // scheduler shadow state
    logic [prts_pkg::PRIO_W-1:0]  sh_prio  [NTASK];
    logic                         sh_ready [NTASK];
    logic                         sh_susp  [NTASK];
    logic [prts_pkg::NEST_W-1:0]  sh_nest  [NTASK];
    logic                         sh_dreq  [NTASK];
    logic [prts_pkg::DISP_W-1:0]  sh_disp  [NTASK];
    logic [prts_pkg::STAMP_W-1:0] sh_stamp [NTASK];
    logic [prts_pkg::ID_W-1:0]    sh_running;
    logic [prts_pkg::LOCK_W-1:0]  sh_lock;

    op_t  pending_ops[$];
    res_t expected_results[$];
    int   error_count = 0;
    bit   quiet_phase = 0;
    bit   hold_long = 0;
    bit   in_taken = 0;
    int   idle_tx = 0;
    int   idle_rx = 0;

    task automatic shadow_reset();
        for (int i = 0; i < NTASK; i++)
        begin
            sh_prio[i] = '0; sh_ready[i] = 0; sh_susp[i] = 0; sh_nest[i] = '0;
            sh_dreq[i] = 0; sh_disp[i] = '0; sh_stamp[i] = '0;
        end
        sh_running = '0;
        sh_lock = '0;
    endtask

    function automatic void insert_newest(int t);
        for (int k = 0; k < NTASK; k++)
        begin
            if (k != t && sh_ready[k] && sh_prio[k] == sh_prio[t]
                && sh_stamp[k] < prts_pkg::STAMP_MAX)
                sh_stamp[k]++;
        end
        sh_stamp[t] = '0;
        sh_ready[t] = 1;
    endfunction

    function automatic bit pick_and_dispatch();
        int  best;
        bit  found;
        best = 0;
        found = 0;
        if (sh_lock != 0)
            return 0;
        for (int t = 0; t < NTASK; t++)
        begin
            if (sh_ready[t] && (!found || sh_prio[t] < sh_prio[best] ||
                (sh_prio[t] == sh_prio[best] && sh_stamp[t] < sh_stamp[best])))
            begin
                best = t;
                found = 1;
            end
        end
        if (!found || best == sh_running)
            return 0;
        sh_running = best[prts_pkg::ID_W-1:0];
        sh_disp[best]++;
        return 1;
    endfunction

    // apply one operation to the shadow state and return its result
    function automatic res_t schedule_op(op_t op);
        res_t r;
        int   t;
        bit   sw;
        bit   addressed;
        bit   any_ready;
        t = op.task_id;
        sw = 0;
        addressed = op.mode != prts_pkg::MODE_LOCK && op.mode != prts_pkg::MODE_UNLOCK
                    && op.mode != 3'd7;
        case (op.mode)
            prts_pkg::MODE_CREATE:
            begin
                sh_ready[t] = 0;
                sh_prio[t] = op.prio;
                sh_susp[t] = 0; sh_nest[t] = '0; sh_dreq[t] = 0; sh_disp[t] = '0;
                insert_newest(t);
            end
            prts_pkg::MODE_SUSPEND:
            begin
                if (sh_nest[t] < prts_pkg::NEST_MAX)
                    sh_nest[t]++;
                if (sh_nest[t] == 1)
                begin
                    sh_susp[t] = 1;
                    sh_ready[t] = 0;
                    if (t == sh_running)
                        sw = pick_and_dispatch();
                end
            end
            prts_pkg::MODE_WAKEUP:
            begin
                if (sh_susp[t])
                begin
                    sh_nest[t]--;
                    if (sh_nest[t] == 0)
                    begin
                        sh_susp[t] = 0;
                        insert_newest(t);
                        sw = pick_and_dispatch();
                    end
                end
            end
            prts_pkg::MODE_DELETE:
            begin
                if (!sh_susp[t])
                    sh_ready[t] = 0;
                if (t == sh_running)
                    sw = pick_and_dispatch();
            end
            prts_pkg::MODE_LOCK:
            begin
                if (sh_lock < prts_pkg::LOCK_MAX)
                    sh_lock++;
            end
            prts_pkg::MODE_UNLOCK:
            begin
                if (sh_lock > 0)
                begin
                    sh_lock--;
                    if (sh_lock == 0)
                        sw = pick_and_dispatch();
                end
            end
            prts_pkg::MODE_REQDEL: sh_dreq[t] = 1;
            default: ;
        endcase
        any_ready = 0;
        for (int k = 0; k < NTASK; k++)
            any_ready |= sh_ready[k];
        r.current_task = sh_running;
        r.switched = sw;
        r.none_ready = !any_ready;
        r.current_delete_requested = sh_dreq[sh_running];
        r.addressed_dispatches = addressed ? sh_disp[t] : '0;
        r.addressed_suspend_count = addressed ? sh_nest[t] : '0;
        r.lock_depth = sh_lock;
        return r;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        error_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    function automatic op_t make_op(logic [2:0] m, int id, int p);
        op_t o;
        o.mode = m;
        o.task_id = id[prts_pkg::ID_W-1:0];
        o.prio = p[prts_pkg::PRIO_W-1:0];
        return o;
    endfunction

    // request acceptance, prediction of its result
    always @(posedge clk)
    begin
        in_taken = rst_n && req_ch.valid && req_ch.ready;
        if (in_taken)
        begin
            void'(pending_ops.pop_front());
            expected_results.push_back(schedule_op({req_ch.mode, req_ch.task_id,
                                                    req_ch.prio}));
        end
    end

    // request driver
    always @(negedge clk)
    begin
        bit in_wait;
        in_wait = req_ch.valid && !in_taken;
        if (rst_n)
        begin
            if (idle_tx > 0)
            begin
                idle_tx--;
                req_ch.valid <= 1'b0;
            end
            else if (!quiet_phase && !in_wait && $urandom_range(0, 9) == 0)
            begin
                idle_tx = $urandom_range(1, 13);
                req_ch.valid <= 1'b0;
            end
            else if (in_wait || pending_ops.size() > 0)
            begin
                if (!in_wait)
                begin
                    req_ch.mode <= pending_ops[0].mode;
                    req_ch.task_id <= pending_ops[0].task_id;
                    req_ch.prio <= pending_ops[0].prio;
                end
                req_ch.valid <= 1'b1;
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // sink-side stalls
    always @(negedge clk)
    begin
        if (!rst_n || hold_long)
            res_ch.ready <= 1'b0;
        else if (idle_rx > 0)
        begin
            idle_rx--;
            res_ch.ready <= 1'b0;
        end
        else if (!quiet_phase && $urandom_range(0, 9) == 0)
        begin
            idle_rx = $urandom_range(1, 13);
            res_ch.ready <= 1'b0;
        end
        else
            res_ch.ready <= 1'b1;
    end

    // result monitor
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("unexpected result", 1, 0);
            else
            begin
                want = expected_results.pop_front();
                if (res_ch.current_task !== want.current_task)
                    report_mismatch("current_task", res_ch.current_task, want.current_task);
                if (res_ch.switched !== want.switched)
                    report_mismatch("switched", res_ch.switched, want.switched);
                if (res_ch.none_ready !== want.none_ready)
                    report_mismatch("none_ready", res_ch.none_ready, want.none_ready);
                if (res_ch.current_delete_requested !== want.current_delete_requested)
                    report_mismatch("current_delete_requested",
                                    res_ch.current_delete_requested,
                                    want.current_delete_requested);
                if (res_ch.addressed_dispatches !== want.addressed_dispatches)
                    report_mismatch("addressed_dispatches", res_ch.addressed_dispatches,
                                    want.addressed_dispatches);
                if (res_ch.addressed_suspend_count !== want.addressed_suspend_count)
                    report_mismatch("addressed_suspend_count",
                                    res_ch.addressed_suspend_count,
                                    want.addressed_suspend_count);
                if (res_ch.lock_depth !== want.lock_depth)
                    report_mismatch("lock_depth", res_ch.lock_depth, want.lock_depth);
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        int stuck;
        if (!rst_n || (req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready))
            stuck = 0;
        else
        begin
            stuck++;
            if (stuck >= WD_LIMIT)
            begin
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    // stimulus
    initial
    begin
        int m;
        int id;
        req_ch.valid = 1'b0;
        req_ch.mode = '0;
        req_ch.task_id = '0;
        req_ch.prio = '0;
        res_ch.ready = 1'b0;
        shadow_reset();

        // directed: extremes, every mode, unused mode, saturations
        pending_ops.push_back(make_op(prts_pkg::MODE_SUSPEND, 9, 0));   // never created
        pending_ops.push_back(make_op(prts_pkg::MODE_DELETE, 0, 0));    // nothing ready
        pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, 15, 31));
        pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, 0, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, 3, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, 5, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_DELETE, 0, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_REQDEL, 5, 21));
        pending_ops.push_back(make_op(prts_pkg::MODE_LOCK, 10, 7));
        pending_ops.push_back(make_op(prts_pkg::MODE_SUSPEND, 5, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_SUSPEND, 5, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_UNLOCK, 2, 9));
        pending_ops.push_back(make_op(prts_pkg::MODE_WAKEUP, 5, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_WAKEUP, 5, 0));
        pending_ops.push_back(make_op(prts_pkg::MODE_WAKEUP, 7, 0));
        pending_ops.push_back(make_op(3'd7, 15, 31));
        pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, 5, 31));   // move a ready task
        pending_ops.push_back(make_op(prts_pkg::MODE_UNLOCK, 0, 0));    // unlock at zero
        for (int i = 0; i < 257; i++)
            pending_ops.push_back(make_op(prts_pkg::MODE_LOCK, 0, 0));
        for (int i = 0; i < 257; i++)
            pending_ops.push_back(make_op(prts_pkg::MODE_SUSPEND, 3, 0));
        for (int i = 0; i < 256; i++)
            pending_ops.push_back(make_op(prts_pkg::MODE_UNLOCK, 0, 0));

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // random: mostly create/suspend/wakeup churn on few priorities
        for (int i = 0; i < 360; i++)
        begin
            id = $urandom_range(0, 15);
            m = $urandom_range(0, 99);
            if (m < 25)
                pending_ops.push_back(make_op(prts_pkg::MODE_CREATE, id,
                    ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3)));
            else if (m < 45)
                pending_ops.push_back(make_op(prts_pkg::MODE_SUSPEND, id, $urandom));
            else if (m < 65)
                pending_ops.push_back(make_op(prts_pkg::MODE_WAKEUP, id, $urandom));
            else if (m < 75)
                pending_ops.push_back(make_op(prts_pkg::MODE_DELETE, id, $urandom));
            else if (m < 83)
                pending_ops.push_back(make_op(prts_pkg::MODE_LOCK, id, $urandom));
            else if (m < 92)
                pending_ops.push_back(make_op(prts_pkg::MODE_UNLOCK, id, $urandom));
            else if (m < 98)
                pending_ops.push_back(make_op(prts_pkg::MODE_REQDEL, id, $urandom));
            else
                pending_ops.push_back(make_op(3'd7, id, $urandom));
        end

        // receiver holds off while the sender keeps offering
        wait (pending_ops.size() < 900);
        hold_long = 1;
        repeat (300) @(posedge clk);
        hold_long = 0;

        wait (pending_ops.size() < 150);
        quiet_phase = 1;
        wait (pending_ops.size() == 0 && expected_results.size() == 0);
        repeat (50) @(posedge clk);
        if (error_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
